// ===== hw/rtl/sync_word_packet_deframer_macros.svh =====
// Assertion macros used by the deframer top level.
`ifndef SYNC_WORD_PACKET_DEFRAMER_MACROS_SVH
`define SYNC_WORD_PACKET_DEFRAMER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWPD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deframer same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SWPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deframer next-cycle check failed");

`endif

// ===== hw/rtl/swpd_pkg.sv =====
// Shared types and constants of the sync word packet deframer.
package swpd_pkg;

   localparam logic [31:0] SyncReset = 32'h55AA77CC;

   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   typedef struct packed {
      logic [7:0]  body_byte;
      logic [31:0] command;
      logic [31:0] body_length;
      logic        first_of_packet;
      logic        last_of_packet;
      logic        empty_packet;
   } rsp_entry_type;

   typedef struct packed {
      logic full;
      logic avail;
   } queue_status_type;

endpackage

// ===== hw/rtl/sync_word_packet_deframer.sv =====
// Top level of the sync word packet deframer.
// Throughput: one word per cycle, sustained; the front end handles each word as it arrives and
// the input stalls only while the four-entry result queue is full.
// Path: a result is written into the result queue at the edge that accepts its word, then
// moved into the output register once that register is empty or being taken.
// Reset (synchronous): sync word 0x55AA77CC, hunting with an empty window, queue empty.
// There is no clearing pass; words are taken from the first cycle after reset.
`include "sync_word_packet_deframer_macros.svh"

module sync_word_packet_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_byte_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_body_byte,
   output logic [31:0] rsp_command,
   output logic [31:0] rsp_body_length,
   output logic        rsp_first_of_packet,
   output logic        rsp_last_of_packet,
   output logic        rsp_empty_packet
);

   swpd_pkg::queue_status_type q_status;
   swpd_pkg::rsp_entry_type    push_entry;
   swpd_pkg::rsp_entry_type    pop_entry;
   swpd_pkg::rsp_entry_type    rsp_entry;
   logic                       push;
   logic                       pop;

   swpd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_byte_in (req_byte_in),
      .q_status    (q_status),
      .push        (push),
      .push_entry  (push_entry)
   );

   swpd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .q_status   (q_status)
   );

   swpd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .pop_entry (pop_entry),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_entry (rsp_entry)
   );

   assign rsp_body_byte       = rsp_entry.body_byte;
   assign rsp_command         = rsp_entry.command;
   assign rsp_body_length     = rsp_entry.body_length;
   assign rsp_first_of_packet = rsp_entry.first_of_packet;
   assign rsp_last_of_packet  = rsp_entry.last_of_packet;
   assign rsp_empty_packet    = rsp_entry.empty_packet;

   `SWPD_ASSERT_SAME(a_no_push_when_full, clock, reset, push, !q_status.full)
   `SWPD_ASSERT_SAME(a_no_pop_when_empty, clock, reset, pop, q_status.avail)
   `SWPD_ASSERT_SAME(a_empty_is_whole, clock, reset, rsp_valid && rsp_empty_packet,
      rsp_first_of_packet && rsp_last_of_packet && (rsp_body_byte == 8'd0))

endmodule

// ===== hw/rtl/swpd_front.sv =====
// Front end: accepts words, hunts for the sync word, captures the header and tags body words.
module swpd_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [31:0]                csr_wr_data,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [7:0]                 req_byte_in,
   input  swpd_pkg::queue_status_type q_status,
   output logic                       push,
   output swpd_pkg::rsp_entry_type    push_entry
);

   typedef enum logic [1:0] {
      PH_HUNT = 2'd0,
      PH_HEAD = 2'd1,
      PH_BODY = 2'd2
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [31:0] sync_word_ff;
   logic [31:0] window_ff, window_in;
   logic [2:0]  fill_ff, fill_in;
   logic [2:0]  hdr_cnt_ff, hdr_cnt_in;
   logic [31:0] command_ff, command_in;
   logic [31:0] length_ff, length_in;
   logic [31:0] left_ff, left_in;
   logic        accept;
   logic        last;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;

   always_comb begin
      phase_in   = phase_ff;
      window_in  = window_ff;
      fill_in    = fill_ff;
      hdr_cnt_in = hdr_cnt_ff;
      command_in = command_ff;
      length_in  = length_ff;
      left_in    = left_ff;
      last       = 1'b0;
      push       = 1'b0;
      push_entry.body_byte       = req_byte_in;
      push_entry.command         = command_ff;
      push_entry.body_length     = length_ff;
      push_entry.first_of_packet = 1'b0;
      push_entry.last_of_packet  = 1'b0;
      push_entry.empty_packet    = 1'b0;
      if (accept) begin
         case (phase_ff)
            PH_HEAD: begin
               for (int i = 0; i < 4; i++) begin
                  if (hdr_cnt_ff[1:0] == 2'(i)) begin
                     if (hdr_cnt_ff[2]) begin
                        length_in[8*i +: 8] = req_byte_in;
                     end else begin
                        command_in[8*i +: 8] = req_byte_in;
                     end
                  end
               end
               hdr_cnt_in = hdr_cnt_ff + 3'd1;
               if (hdr_cnt_ff == 3'd7) begin
                  if (length_in == 32'd0) begin
                     push = 1'b1;
                     push_entry.body_byte       = 8'd0;
                     push_entry.body_length     = length_in;
                     push_entry.first_of_packet = 1'b1;
                     push_entry.last_of_packet  = 1'b1;
                     push_entry.empty_packet    = 1'b1;
                     phase_in  = PH_HUNT;
                     window_in = 32'd0;
                     fill_in   = 3'd0;
                  end else begin
                     left_in  = length_in;
                     phase_in = PH_BODY;
                  end
               end
            end
            PH_BODY: begin
               last = (left_ff[31:1] == 31'd0);
               push = 1'b1;
               push_entry.first_of_packet = (left_ff == length_ff);
               push_entry.last_of_packet  = last;
               left_in = left_ff - 32'd1;
               if (last) begin
                  phase_in  = PH_HUNT;
                  window_in = 32'd0;
                  fill_in   = 3'd0;
               end
            end
            default: begin
               window_in = {req_byte_in, window_ff[31:8]};
               if (fill_ff < 3'd4) begin
                  fill_in = fill_ff + 3'd1;
               end
               if ((fill_ff >= 3'd3) && (window_in == sync_word_ff)) begin
                  phase_in   = PH_HEAD;
                  hdr_cnt_in = 3'd0;
                  window_in  = 32'd0;
                  fill_in    = 3'd0;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         sync_word_ff <= swpd_pkg::SyncReset;
         window_ff    <= 32'd0;
         fill_ff      <= 3'd0;
         hdr_cnt_ff   <= 3'd0;
         command_ff   <= 32'd0;
         length_ff    <= 32'd0;
         left_ff      <= 32'd0;
      end else begin
         phase_ff   <= phase_in;
         window_ff  <= window_in;
         fill_ff    <= fill_in;
         hdr_cnt_ff <= hdr_cnt_in;
         command_ff <= command_in;
         length_ff  <= length_in;
         left_ff    <= left_in;
         if (csr_wr_en) begin
            sync_word_ff <= csr_wr_data;
         end
      end
   end

endmodule

// ===== hw/rtl/swpd_queue.sv =====
// Short result queue between the front end and the output stage.
module swpd_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  swpd_pkg::rsp_entry_type    push_entry,
   input  logic                       pop,
   output swpd_pkg::rsp_entry_type    pop_entry,
   output swpd_pkg::queue_status_type q_status
);

   swpd_pkg::rsp_entry_type               entry_ff [swpd_pkg::QueueDepth];
   logic [swpd_pkg::QueuePtrW-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [swpd_pkg::QueuePtrW-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [swpd_pkg::QueueCntW-1:0]        count_ff, count_in;

   localparam logic [swpd_pkg::QueuePtrW-1:0] PtrLast =
      swpd_pkg::QueuePtrW'(swpd_pkg::QueueDepth - 1);
   localparam logic [swpd_pkg::QueuePtrW-1:0] PtrOne = swpd_pkg::QueuePtrW'(1);
   localparam logic [swpd_pkg::QueueCntW-1:0] CntFull =
      swpd_pkg::QueueCntW'(swpd_pkg::QueueDepth);
   localparam logic [swpd_pkg::QueueCntW-1:0] CntOne = swpd_pkg::QueueCntW'(1);

   assign q_status.full  = (count_ff == CntFull);
   assign q_status.avail = (count_ff != '0);
   assign pop_entry      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + PtrOne;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + PtrOne;
      end
      if (push && !pop) begin
         count_in = count_ff + CntOne;
      end else if (pop && !push) begin
         count_in = count_ff - CntOne;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== hw/rtl/swpd_back.sv =====
// Output stage: registers one queued result and holds it while the consumer stalls.
module swpd_back (
   input  logic                       clock,
   input  logic                       reset,
   input  swpd_pkg::queue_status_type q_status,
   input  swpd_pkg::rsp_entry_type    pop_entry,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output swpd_pkg::rsp_entry_type    rsp_entry
);

   logic                    valid_ff;
   swpd_pkg::rsp_entry_type entry_ff;

   assign pop       = q_status.avail && (!valid_ff || !rsp_stall);
   assign rsp_valid = valid_ff;
   assign rsp_entry = entry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!valid_ff || !rsp_stall) begin
         valid_ff <= q_status.avail;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         entry_ff <= pop_entry;
      end
   end

endmodule

// ===== tb/tb_sync_word_packet_deframer.sv =====
// Self-checking testbench for the sync word packet deframer.
module tb_sync_word_packet_deframer;

   typedef enum logic [1:0] {HUNTING, IN_HEADER, IN_BODY} frame_phase_type;

   typedef struct packed {
      logic [7:0]              word;
      logic                    typed;
      swpd_pkg::rsp_entry_type rsp;
   } stim_row_type;

   localparam swpd_pkg::rsp_entry_type NO_RSP = '0;
   localparam int DIRECTED_ROWS = 25;
   localparam int HOLD_CYCLES = 150;
   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_LIMIT = 100000;

   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{8'hCC, 1'b0, NO_RSP}, '{8'h77, 1'b0, NO_RSP},
      '{8'hAA, 1'b0, NO_RSP}, '{8'h55, 1'b0, NO_RSP},
      '{8'hFF, 1'b0, NO_RSP}, '{8'hFF, 1'b0, NO_RSP},
      '{8'hFF, 1'b0, NO_RSP}, '{8'hFF, 1'b0, NO_RSP},
      '{8'h00, 1'b0, NO_RSP}, '{8'h00, 1'b0, NO_RSP}, '{8'h00, 1'b0, NO_RSP},
      '{8'h00, 1'b1, '{8'h00, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 1'b1}},
      '{8'hCC, 1'b0, NO_RSP}, '{8'h77, 1'b0, NO_RSP},
      '{8'hAA, 1'b0, NO_RSP}, '{8'h55, 1'b0, NO_RSP},
      '{8'h00, 1'b0, NO_RSP}, '{8'h00, 1'b0, NO_RSP},
      '{8'h00, 1'b0, NO_RSP}, '{8'h00, 1'b0, NO_RSP},
      '{8'h01, 1'b0, NO_RSP}, '{8'h00, 1'b0, NO_RSP},
      '{8'h00, 1'b0, NO_RSP}, '{8'h00, 1'b0, NO_RSP},
      '{8'hFF, 1'b1, '{8'hFF, 32'h0000_0000, 32'h0000_0001, 1'b1, 1'b1, 1'b0}}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [31:0] csr_wr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_byte_in = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_body_byte;
   logic [31:0] rsp_command;
   logic [31:0] rsp_body_length;
   logic        rsp_first_of_packet;
   logic        rsp_last_of_packet;
   logic        rsp_empty_packet;

   logic [31:0]     hunt_pattern;
   frame_phase_type frame_phase;
   logic [31:0]     sync_window;
   int              window_fill;
   int              header_count;
   logic [31:0]     command_word;
   logic [31:0]     length_word;
   logic [31:0]     bytes_left;

   swpd_pkg::rsp_entry_type deframed_q [$];

   int req_gap_pct = 24;
   int rsp_gap_pct = 52;
   int hold_req = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int items_sent = 0;
   int packets_sent = 0;
   int results_checked = 0;
   int mismatch_count = 0;

   sync_word_packet_deframer u_top (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_byte_in         (req_byte_in),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_body_byte       (rsp_body_byte),
      .rsp_command         (rsp_command),
      .rsp_body_length     (rsp_body_length),
      .rsp_first_of_packet (rsp_first_of_packet),
      .rsp_last_of_packet  (rsp_last_of_packet),
      .rsp_empty_packet    (rsp_empty_packet)
   );

   always #5 clock = ~clock;

   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

   function automatic void restart_hunt();
      frame_phase = HUNTING;
      sync_window = '0;
      window_fill = 0;
   endfunction

   function automatic void reset_deframer_model();
      hunt_pattern = swpd_pkg::SyncReset;
      restart_hunt();
      header_count = 0;
      command_word = '0;
      length_word = '0;
      bytes_left = '0;
   endfunction

   function automatic void deframe_byte(input logic [7:0] b, output bit produced,
                                        output swpd_pkg::rsp_entry_type r);
      produced = 1'b0;
      r = '0;
      case (frame_phase)
         IN_HEADER: begin
            if (header_count < 4) command_word[8*header_count +: 8] = b;
            else length_word[8*(header_count-4) +: 8] = b;
            header_count = (header_count + 1) & 7;
            if (header_count == 0) begin
               if (length_word == 0) begin
                  r = '{8'h00, command_word, length_word, 1'b1, 1'b1, 1'b1};
                  produced = 1'b1;
                  restart_hunt();
               end else begin
                  bytes_left = length_word;
                  frame_phase = IN_BODY;
               end
            end
         end
         IN_BODY: begin
            r.body_byte = b;
            r.command = command_word;
            r.body_length = length_word;
            r.first_of_packet = (bytes_left == length_word);
            r.last_of_packet = (bytes_left <= 1);
            r.empty_packet = 1'b0;
            produced = 1'b1;
            bytes_left = bytes_left - 1;
            if (r.last_of_packet) restart_hunt();
         end
         default: begin
            sync_window = {b, sync_window[31:8]};
            if (window_fill < 4) window_fill++;
            if (window_fill >= 4 && sync_window == hunt_pattern) begin
               frame_phase = IN_HEADER;
               header_count = 0;
               sync_window = '0;
               window_fill = 0;
            end else begin
               frame_phase = HUNTING;
            end
         end
      endcase
   endfunction

   function automatic void note_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("MISMATCH at %0t: %s", $realtime, msg);
   endfunction

   function automatic void compare_result(input swpd_pkg::rsp_entry_type want,
                                          input swpd_pkg::rsp_entry_type got);
      if (got.body_byte !== want.body_byte)
         note_mismatch($sformatf("body_byte expected %02h got %02h",
                                 want.body_byte, got.body_byte));
      if (got.command !== want.command)
         note_mismatch($sformatf("command expected %08h got %08h", want.command, got.command));
      if (got.body_length !== want.body_length)
         note_mismatch($sformatf("body_length expected %08h got %08h",
                                 want.body_length, got.body_length));
      if (got.first_of_packet !== want.first_of_packet)
         note_mismatch($sformatf("first_of_packet expected %b got %b",
                                 want.first_of_packet, got.first_of_packet));
      if (got.last_of_packet !== want.last_of_packet)
         note_mismatch($sformatf("last_of_packet expected %b got %b",
                                 want.last_of_packet, got.last_of_packet));
      if (got.empty_packet !== want.empty_packet)
         note_mismatch($sformatf("empty_packet expected %b got %b",
                                 want.empty_packet, got.empty_packet));
   endfunction

   always @(posedge clock) begin : rsp_side
      swpd_pkg::rsp_entry_type seen;
      swpd_pkg::rsp_entry_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         seen = {rsp_body_byte, rsp_command, rsp_body_length,
                 rsp_first_of_packet, rsp_last_of_packet, rsp_empty_packet};
         if (deframed_q.size() == 0) begin
            note_mismatch($sformatf("unexpected result, body_byte %02h command %08h",
                                    seen.body_byte, seen.command));
         end else begin
            want = deframed_q.pop_front();
            compare_result(want, seen);
         end
         results_checked++;
      end
      if (hold_req != hold_seen) begin
         hold_seen = hold_req;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_gap_pct);
      end
   end

   task automatic offer_byte(input logic [7:0] b);
      if ($urandom_range(99) < req_gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_byte_in <= b;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      items_sent++;
   endtask

   task automatic feed_byte(input logic [7:0] b);
      bit produced;
      swpd_pkg::rsp_entry_type r;
      offer_byte(b);
      deframe_byte(b, produced, r);
      if (produced) deframed_q.push_back(r);
   endtask

   // Noise must never complete a sync word, otherwise the stream falls out of step.
   task automatic feed_noise(input logic [7:0] b);
      if (frame_phase == HUNTING && window_fill >= 3 &&
          {b, sync_window[31:8]} == hunt_pattern) b = ~b;
      feed_byte(b);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (deframed_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_sync_word(input logic [31:0] value);
      wait_drained();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      hunt_pattern = value;
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(7))
         0: return hunt_pattern[8*$urandom_range(3) +: 8];
         1: return 8'h00;
         2: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] pick_command();
      case ($urandom_range(9))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_length();
      int p;
      p = $urandom_range(99);
      if (p < 10) return 32'd0;
      if (p < 75) return $urandom_range(8, 1);
      if (p < 95) return $urandom_range(40, 9);
      return $urandom_range(260, 41);
   endfunction

   task automatic send_packet(input logic [31:0] cmd, input logic [31:0] len,
                              input int body_words);
      logic [31:0] pattern;
      pattern = hunt_pattern;
      for (int i = 0; i < 4 && frame_phase == HUNTING; i++) feed_byte(pattern[8*i +: 8]);
      for (int i = 0; i < 4; i++) feed_byte(cmd[8*i +: 8]);
      for (int i = 0; i < 4; i++) feed_byte(len[8*i +: 8]);
      repeat (body_words) feed_byte(pick_byte());
      packets_sent++;
   endtask

   task automatic random_frame();
      logic [31:0] len;
      int k;
      repeat ($urandom_range(5)) feed_noise(pick_byte());
      if ($urandom_range(99) < 80) begin
         len = pick_length();
         send_packet(pick_command(), len, len);
      end else begin
         k = $urandom_range(3, 1);
         for (int i = 0; i < k; i++) feed_noise(hunt_pattern[8*i +: 8]);
         feed_noise(pick_byte());
      end
   endtask

   task automatic run_random_until(input int target);
      while (items_sent < target) random_frame();
   endtask

   initial begin : stimulus
      swpd_pkg::rsp_entry_type r;
      bit produced;
      int waited;
      reset_deframer_model();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         offer_byte(DIRECTED[i].word);
         deframe_byte(DIRECTED[i].word, produced, r);
         if (DIRECTED[i].typed) deframed_q.push_back(DIRECTED[i].rsp);
         else if (produced) deframed_q.push_back(r);
      end

      write_sync_word(32'h0000_0000);
      run_random_until(375);

      req_gap_pct = 52;
      rsp_gap_pct = 24;
      write_sync_word(32'hFFFF_FFFF);
      hold_req <= hold_req + 1;
      send_packet($urandom, 32'd40, 40);
      run_random_until(725);

      req_gap_pct = 0;
      rsp_gap_pct = 0;
      write_sync_word($urandom);
      run_random_until(900);
      wait_drained();
      run_random_until(1075);

      write_sync_word(swpd_pkg::SyncReset);
      run_random_until(1400);
      send_packet($urandom, 32'h8000_0000 | $urandom, 30);

      req_valid <= 1'b0;
      waited = 0;
      while (deframed_q.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (deframed_q.size() != 0)
         note_mismatch($sformatf("%0d expected results never arrived", deframed_q.size()));

      $display("Covered %0d words offered, %0d packets framed, %0d results checked.",
               items_sent, packets_sent, results_checked);
      $display("Sync words used: reset value, all zeros, all ones and a random one.");
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== sync_word_packet_deframer.f =====
+incdir+hw/rtl
hw/rtl/swpd_pkg.sv
hw/rtl/swpd_front.sv
hw/rtl/swpd_queue.sv
hw/rtl/swpd_back.sv
hw/rtl/sync_word_packet_deframer.sv
tb/tb_sync_word_packet_deframer.sv
